@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ design/crc36_pkg.sv @@
// Types, constants and helper functions for the CRC-32 base-36 hash.
package crc36_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // 1679616 = 6561 * 256, 1296 = 81 * 16, 36 = 9 * 4
  localparam logic [12:0] MOD_ODD   = 13'd6561;
  localparam logic [23:0] MOD_RECIP = 24'd10473933;   // floor(2^36 / 6561)
  localparam logic [6:0]  SPL_ODD   = 7'd81;
  localparam logic [17:0] SPL_RECIP = 18'd207126;     // floor(2^24 / 81)
  localparam logic [3:0]  DIG_ODD   = 4'd9;
  localparam logic [8:0]  DIG_RECIP = 9'd455;         // floor(2^12 / 9)

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_ALPHA = 7'd87;         // 'a' - 10
  localparam logic [6:0] ASCII_LOW_Z = 7'd122;
  localparam logic [6:0] ASCII_NINE  = 7'd57;
  localparam logic [6:0] ASCII_LOW_A = 7'd97;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;
  } in_req_t;

  typedef struct packed {
    logic [6:0] hash_char0;
    logic [6:0] hash_char1;
    logic [6:0] hash_char2;
    logic [6:0] hash_char3;
  } out_res_t;

  typedef struct packed {
    logic [5:0] quo;
    logic [5:0] rem;
  } div36_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_gen_table();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_gen_table();

  // v < 1296: split into v / 36 and v % 36
  function automatic div36_t div36(input logic [10:0] v);
    div36_t      res;
    logic [8:0]  t;
    logic [17:0] p;
    logic [5:0]  q;
    logic [9:0]  qm;
    logic [8:0]  rm;
    t  = v[10:2];
    p  = 18'(t) * 18'(DIG_RECIP);
    q  = p[17:12];
    qm = 10'(q) * 10'(DIG_ODD);
    rm = t - qm[8:0];
    if (rm >= 9'(DIG_ODD)) begin
      q  = q + 6'd1;
      rm = rm - 9'(DIG_ODD);
    end
    res.quo = q;
    res.rem = {rm[3:0], v[1:0]};
    return res;
  endfunction

  function automatic logic [6:0] to_ascii(input logic [5:0] d);
    return (d < 6'd10) ? (ASCII_ZERO + 7'(d)) : (ASCII_ALPHA + 7'(d));
  endfunction

endpackage

@@ design/crc32_base36_short_hash.sv @@
// CRC-32 byte-stream hash, emitted as four base-36 ASCII characters.
// Throughput: one request per cycle while in_stall is low; the CRC is updated as the request is taken.
// A last request's hash reaches out_valid through the pipeline stages and the output register; out_stall can hold it.
// Five pipeline stages plus the output register carry the modulo and digit split.
// Reset (rst_n low, synchronous): CRC to all ones, every stage and out_valid empty.
`include "assert_macros.svh"

module crc32_base36_short_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crc36_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crc36_pkg::out_res_t out_data
);
  import crc36_pkg::*;

  logic        in_acc;
  logic        rdy_o, rdy1, rdy2, rdy3, rdy4, rdy5;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic [31:0] crc_r, crc_nxt, crc_upd;

  logic [31:0] fin_r;
  logic [47:0] prod1;
  logic [11:0] q1_r;
  logic [23:0] x1_r;
  logic [7:0]  lo8_r;
  logic [24:0] qm1;
  logic [23:0] rp1;
  logic [12:0] r13;
  logic [20:0] r21_r;
  logic [34:0] prod2;
  logic [10:0] q2h_r;
  logic [16:0] y2_r;
  logic [3:0]  lo4_r;
  logic [17:0] qm2;
  logic [16:0] rp2;
  logic [10:0] q2;
  logic [6:0]  rem2;
  logic [10:0] hi_r, lo_r;
  div36_t      dh, dl;
  out_res_t    res_nxt, out_data_r;

  assign rdy_o    = !out_valid_r || !out_stall;
  assign rdy5     = !v5_r || rdy_o;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_acc   = in_valid && rdy1;

  always_comb begin
    crc_upd = (crc_r >> 8) ^ CRC_TABLE[crc_r[7:0] ^ in_data.data_byte];
    crc_nxt = crc_r;
    if (in_data.has_byte) begin
      crc_nxt = crc_upd;
    end
  end

  assign prod1 = 48'(fin_r[31:8]) * 48'(MOD_RECIP);

  always_comb begin
    qm1 = 25'(q1_r) * 25'(MOD_ODD);
    rp1 = x1_r - qm1[23:0];
    r13 = (rp1 >= 24'(MOD_ODD)) ? 13'(rp1 - 24'(MOD_ODD)) : rp1[12:0];
  end

  assign prod2 = 35'(r21_r[20:4]) * 35'(SPL_RECIP);

  always_comb begin
    qm2  = 18'(q2h_r) * 18'(SPL_ODD);
    rp2  = y2_r - qm2[16:0];
    q2   = q2h_r;
    rem2 = rp2[6:0];
    if (rp2 >= 17'(SPL_ODD)) begin
      q2   = q2h_r + 11'd1;
      rem2 = 7'(rp2 - 17'(SPL_ODD));
    end
  end

  always_comb begin
    dh = div36(hi_r);
    dl = div36(lo_r);
    res_nxt.hash_char0 = to_ascii(dh.quo);
    res_nxt.hash_char1 = to_ascii(dh.rem);
    res_nxt.hash_char2 = to_ascii(dl.quo);
    res_nxt.hash_char3 = to_ascii(dl.rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_ONES;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        crc_r <= in_data.last_item ? CRC_ONES : crc_nxt;
      end
      if (rdy1)  v1_r        <= in_acc && in_data.last_item;
      if (rdy2)  v2_r        <= v1_r;
      if (rdy3)  v3_r        <= v2_r;
      if (rdy4)  v4_r        <= v3_r;
      if (rdy5)  v5_r        <= v4_r;
      if (rdy_o) out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      fin_r <= crc_nxt ^ CRC_ONES;
    end
    if (rdy2) begin
      q1_r  <= prod1[47:36];
      x1_r  <= fin_r[31:8];
      lo8_r <= fin_r[7:0];
    end
    if (rdy3) begin
      r21_r <= {r13, lo8_r};
    end
    if (rdy4) begin
      q2h_r <= prod2[34:24];
      y2_r  <= r21_r[20:4];
      lo4_r <= r21_r[3:0];
    end
    if (rdy5) begin
      hi_r <= q2;
      lo_r <= {rem2, lo4_r};
    end
    if (rdy_o) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_PROP(a_crc_restart, clk, rst_n,
    (in_acc && in_data.last_item) |=> (crc_r == CRC_ONES),
    "CRC not restarted after end of message")
  `ASSERT_PROP(a_stall_full, clk, rst_n,
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r),
    "input stalled while pipeline has room")
  `ASSERT_NEVER(a_bad_char, clk, rst_n,
    out_valid_r && ((out_data_r.hash_char0 < ASCII_ZERO) ||
    (out_data_r.hash_char0 > ASCII_LOW_Z) ||
    ((out_data_r.hash_char0 > ASCII_NINE) && (out_data_r.hash_char0 < ASCII_LOW_A))),
    "first hash character out of range")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the CRC-32 base-36 four-character hash block.
module testbench;
  import crc36_pkg::*;

  localparam logic [31:0] REFL_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
  localparam int unsigned HASH_SPAN = 1679616;
  localparam int unsigned RADIX     = 36;
  localparam int          MAX_WAIT  = 6;
  localparam int          DRAIN_CYC = 24;
  localparam int          RAND_REQS = 400;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  out_res_t    expected_hashes [$];
  logic [31:0] crc_acc = ALL_ONES;
  bit          idle_on = 1'b0;
  int          hold_cnt = 0;
  int          rx_wait = 0;
  int          errors = 0;
  int          msgs_sent = 0;
  int          bytes_sent = 0;
  int          hashes_seen = 0;

  crc32_base36_short_hash i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (REFL_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

  function automatic out_res_t hash_of(input logic [31:0] crc);
    int unsigned v;
    int unsigned d;
    logic [6:0]  ch [4];
    out_res_t    h;
    v = (crc ^ ALL_ONES) % HASH_SPAN;
    for (int i = 3; i >= 0; i--) begin
      d = v % RADIX;
      ch[i] = (d < 10) ? 7'(8'h30 + d) : 7'(8'h61 + d - 10);
      v = v / RADIX;
    end
    h.hash_char0 = ch[0];
    h.hash_char1 = ch[1];
    h.hash_char2 = ch[2];
    h.hash_char3 = ch[3];
    return h;
  endfunction

  task automatic track_request(input in_req_t r);
    if (r.has_byte) begin
      crc_acc = crc_fold(crc_acc, r.data_byte);
      bytes_sent++;
    end
    if (r.last_item) begin
      expected_hashes.push_back(hash_of(crc_acc));
      crc_acc = ALL_ONES;
      msgs_sent++;
    end
  endtask

  task automatic send_req(input logic [7:0] b, input logic hb, input logic lst);
    int      gap;
    in_req_t r;
    r.data_byte = b;
    r.has_byte  = hb;
    r.last_item = lst;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= in_req_t'(10'($urandom));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_request(r);
  endtask

  task automatic send_text(input string s, input bit end_with_byte);
    for (int i = 0; i < s.len(); i++) begin
      send_req(s[i], 1'b1, end_with_byte && (i == s.len() - 1));
    end
    if (!end_with_byte || s.len() == 0) send_req(8'h00, 1'b0, 1'b1);
  endtask

  // receiver stall: long hold-off first, then per-result random wait
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_res_t    want;
    logic [27:0] w;
    logic [27:0] g;
    string       names [4];
    names = '{"hash_char0", "hash_char1", "hash_char2", "hash_char3"};
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      hashes_seen++;
      if (expected_hashes.size() == 0) begin
        $error("unexpected hash %h", out_data);
        errors++;
      end else begin
        want = expected_hashes.pop_front();
        w = want;
        g = out_data;
        for (int i = 0; i < 4; i++) begin
          if (w[27 - 7*i -: 7] !== g[27 - 7*i -: 7]) begin
            $error("%s expected %0d actual %0d", names[i], w[27 - 7*i -: 7],
                   g[27 - 7*i -: 7]);
            errors++;
          end
        end
      end
      rx_wait = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  task automatic test_empty_and_idle();
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'hFF, 1'b0, 1'b0);
    send_req(8'hA5, 1'b0, 1'b0);
    send_req(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_req(8'h00, 1'b1, 1'b1);
    send_req(8'hFF, 1'b1, 1'b1);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_check_string();
    send_text("123456789", 1'b1);
    send_text("abc", 1'b0);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cnt = 300;
    for (int i = 0; i < 40; i++) begin
      send_req(8'($urandom), 1'b1, i[0]);
    end
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages(input int n_reqs);
    int sent;
    int len;
    sent = 0;
    while (sent < n_reqs) begin
      idle_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(20, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_req(8'($urandom), 1'b0, 1'b0);
        send_req(8'($urandom), 1'b1, 1'b0);
        sent++;
      end
      send_req(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_empty_and_idle();
    test_byte_extremes();
    test_check_string();
    test_backpressure();
    test_random_messages(RAND_REQS);
    @(negedge clk);
    in_valid <= 1'b0;
    idle_on = 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d messages, %0d bytes, %0d hashes checked",
             msgs_sent, bytes_sent, hashes_seen);
    $display("incl. empty messages, idle requests, byte-with-end and a long output hold-off");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
